// ----- rtl/core/interval_overlap_sweep_defines.svh -----
// ============================================================================
// Interval overlap sweep: assertion macros
// Shared assertion forms used by the checker of the overlap sweep block.
// ============================================================================
`ifndef INTERVAL_OVERLAP_SWEEP_DEFINES_SVH
`define INTERVAL_OVERLAP_SWEEP_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define IOSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("interval_overlap_sweep: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define IOSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("interval_overlap_sweep: next-cycle check failed");

`endif

// ----- rtl/core/iosw_pkg.sv -----
// ============================================================================
// Interval overlap sweep package
// Shared constants, command and status types of the overlap sweep block.
// ============================================================================
package iosw_pkg;

    // Default sizing of the interval store and the coordinate words.
    localparam int MAX_INTERVALS_DEF = 32;
    localparam int COORD_BITS_DEF    = 16;

    // Width of the signed running count carried by every result word.
    localparam int HC_BITS = 7;

    typedef logic signed [HC_BITS-1:0] t_count;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_DECIDE = 3'b100
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;       // write the accepted interval into the store
        logic pass_start;  // rewind the store walk for a new pass
        logic scan;        // walk the store, one entry a cycle
        logic finish;      // act on the result of the finished pass
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pass_done;   // every stored entry of this pass has been examined
        logic got;         // the pass found a coordinate above the previous one
        logic pend_valid;  // a segment waits to be handed to the output
        logic out_free;    // the output register can take a word this cycle
    } t_dp_stat;

endpackage

// ----- rtl/core/iosw_in_if.sv -----
// ============================================================================
// Interval input channel
// Valid/ready channel carrying one interval word per handshake.
// ============================================================================
interface iosw_in_if import iosw_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] start_year;
    logic [COORD_BITS-1:0] end_year;
    logic                  last_interval;

    modport source (output valid, start_year, end_year, last_interval, input ready);
    modport sink   (input valid, start_year, end_year, last_interval, output ready);
endinterface

// ----- rtl/core/iosw_out_if.sv -----
// ============================================================================
// Segment output channel
// Valid/ready channel carrying one segment word per handshake.
// ============================================================================
interface iosw_out_if import iosw_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] seg_start;
    logic [COORD_BITS-1:0] seg_end;
    t_count                headcount;
    logic                  last_segment;
    logic                  overflow;

    modport source (output valid, seg_start, seg_end, headcount, last_segment, overflow,
                    input ready);
    modport sink   (input valid, seg_start, seg_end, headcount, last_segment, overflow,
                    output ready);
endinterface

// ----- rtl/core/interval_overlap_sweep.sv -----
// ============================================================================
// Interval overlap sweep
// Collects intervals and, on the last of a batch, emits the overlap count of
// every segment between consecutive distinct coordinates.
// ============================================================================
//
//  Channel  Direction  Word                                   Handshake
//  i_in     in         start_year, end_year, last_interval    valid/ready
//  o_out    out        seg_start, seg_end, headcount,         valid/ready
//                      last_segment, overflow
//
// Intervals load at one word per cycle while the block is idle.
// After the last interval, each pass over the N stored intervals issues one
// RAM read per cycle, folds each registered read, sees the end of the pass
// and ends in a decision step; a batch with K distinct coordinates takes
// K + 1 passes and gives K - 1 words.
// The input is held off from the last interval until the final word is in the
// output register; a stalled output holds the sweep at its decision cycle.
// Reset is synchronous and empties the store at once; no clearing pass.
//
module interval_overlap_sweep import iosw_pkg::*; #(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    iosw_in_if.sink           i_in,
    iosw_out_if.source        o_out
);

    t_ctl_cmd cmd;
    t_dp_stat stat;
    logic     in_ready;

    // Sequencing of load, passes and hand-off.
    iosw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_interval),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // Store, search and output register.
    iosw_dp #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .COORD_BITS    (COORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_start_year   (i_in.start_year),
        .i_end_year     (i_in.end_year),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_seg_start    (o_out.seg_start),
        .o_seg_end      (o_out.seg_end),
        .o_headcount    (o_out.headcount),
        .o_last_segment (o_out.last_segment),
        .o_overflow     (o_out.overflow)
    );

endmodule

// ----- rtl/core/iosw_ram.sv -----
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ============================================================================
module iosw_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/iosw_ctrl.sv -----
// ============================================================================
// Interval overlap sweep controller
// Sequences loading, store passes and segment hand-off.
// ============================================================================
module iosw_ctrl import iosw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_last,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_ctl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    if (i_in_last) begin
                        o_cmd.pass_start = 1'b1;
                        n_state          = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.pass_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // A waiting segment may only move on once the output has room.
                if (!i_stat.pend_valid || i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    if (i_stat.got) begin
                        o_cmd.pass_start = 1'b1;
                        n_state          = ST_SCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/iosw_dp.sv -----
// ============================================================================
// Interval overlap sweep datapath
// Interval store, minimum search per pass, running count and output word.
// ============================================================================
module iosw_dp import iosw_pkg::*; #(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl_cmd              i_cmd,
    output t_dp_stat              o_stat,
    input  logic [COORD_BITS-1:0] i_start_year,
    input  logic [COORD_BITS-1:0] i_end_year,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [COORD_BITS-1:0] o_seg_start,
    output logic [COORD_BITS-1:0] o_seg_end,
    output t_count                o_headcount,
    output logic                  o_last_segment,
    output logic                  o_overflow
);

    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);

    // Fill and walk state.
    logic [CW-1:0]         r_count;
    logic                  r_dropped;
    logic [CW-1:0]         r_addr;
    logic                  r_rd_pend;

    // Result of the current pass.
    logic                  r_got;
    logic [COORD_BITS-1:0] r_best;
    t_count                r_d;

    // Sweep position.
    logic                  r_have_prev;
    logic [COORD_BITS-1:0] r_prev;
    t_count                r_sum;

    // Segment waiting to learn whether it is the final one.
    logic                  r_pend_valid;
    logic [COORD_BITS-1:0] r_pend_start;
    logic [COORD_BITS-1:0] r_pend_end;
    t_count                r_pend_count;

    // Output register.
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_seg_start;
    logic [COORD_BITS-1:0] r_seg_end;
    t_count                r_headcount;
    logic                  r_last_segment;
    logic                  r_overflow;

    logic                  room;
    logic                  ram_we;
    logic                  rd_issue;
    logic                  out_free;
    logic [COORD_BITS-1:0] rd_start;
    logic [COORD_BITS-1:0] rd_end;
    logic                  n_got;
    logic [COORD_BITS-1:0] n_best;
    t_count                n_d;

    assign room     = (r_count < CW'(MAX_INTERVALS));
    assign ram_we   = i_cmd.store && room;
    assign rd_issue = (r_addr < r_count);
    assign out_free = !r_out_valid || i_out_ready;

    // Interval store, one RAM for each coordinate.
    iosw_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_INTERVALS)) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_start_year),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rd_start)
    );

    iosw_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_INTERVALS)) u_end_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_end_year),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rd_end)
    );

    // Fold one stored interval into the pass: the smallest coordinate above
    // the previous one, with starts minus ends found at that coordinate.
    always_comb begin
        logic ok_a;
        logic ok_b;
        ok_a   = !r_have_prev || (rd_start > r_prev);
        ok_b   = !r_have_prev || (rd_end > r_prev);
        n_got  = r_got;
        n_best = r_best;
        n_d    = r_d;
        if (ok_a && (!n_got || rd_start < n_best)) begin
            n_got  = 1'b1;
            n_best = rd_start;
            n_d    = t_count'(1);
        end else if (ok_a && rd_start == n_best) begin
            n_d = n_d + t_count'(1);
        end
        if (ok_b && (!n_got || rd_end < n_best)) begin
            n_got  = 1'b1;
            n_best = rd_end;
            n_d    = t_count'(-1);
        end else if (ok_b && rd_end == n_best) begin
            n_d = n_d - t_count'(1);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_dropped    <= 1'b0;
            r_addr       <= '0;
            r_rd_pend    <= 1'b0;
            r_got        <= 1'b0;
            r_have_prev  <= 1'b0;
            r_sum        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // Loading: intervals beyond capacity only mark the batch.
            if (i_cmd.store) begin
                if (room) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_dropped <= 1'b1;
                end
            end

            // Store walk: issue one read a cycle, fold the data in the cycle after its read.
            if (i_cmd.scan) begin
                r_rd_pend <= rd_issue;
                if (rd_issue) begin
                    r_addr <= r_addr + CW'(1);
                end
                if (r_rd_pend) begin
                    r_got <= n_got;
                end
            end

            if (i_cmd.pass_start) begin
                r_addr    <= '0;
                r_rd_pend <= 1'b0;
                r_got     <= 1'b0;
            end

            // Output valid: loaded with the waiting segment, cleared when taken.
            if (i_cmd.finish && r_pend_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // End of pass: advance the sweep, or close the batch.
            if (i_cmd.finish) begin
                if (r_got) begin
                    r_pend_valid <= r_have_prev;
                    r_have_prev  <= 1'b1;
                    r_sum        <= r_sum + r_d;
                end else begin
                    r_count      <= '0;
                    r_dropped    <= 1'b0;
                    r_have_prev  <= 1'b0;
                    r_pend_valid <= 1'b0;
                    r_sum        <= '0;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && r_rd_pend) begin
            r_best <= n_best;
            r_d    <= n_d;
        end
        if (i_cmd.finish && r_got) begin
            r_prev       <= r_best;
            r_pend_start <= r_prev;
            r_pend_end   <= r_best;
            r_pend_count <= r_sum;
        end
        if (i_cmd.finish && r_pend_valid) begin
            r_seg_start    <= r_pend_start;
            r_seg_end      <= r_pend_end;
            r_headcount    <= r_pend_count;
            r_last_segment <= !r_got;
            r_overflow     <= r_dropped;
        end
    end

    // Status towards the controller.
    always_comb begin
        o_stat.pass_done  = !rd_issue && !r_rd_pend;
        o_stat.got        = r_got;
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_free   = out_free;
    end

    assign o_out_valid    = r_out_valid;
    assign o_seg_start    = r_seg_start;
    assign o_seg_end      = r_seg_end;
    assign o_headcount    = r_headcount;
    assign o_last_segment = r_last_segment;
    assign o_overflow     = r_overflow;

endmodule

// ----- rtl/core/iosw_checker.sv -----
// ============================================================================
// Interval overlap sweep checker
// Port-level assertions on the overlap sweep block, attached by bind.
// ============================================================================
`include "interval_overlap_sweep_defines.svh"

module iosw_checker import iosw_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_in_last,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [COORD_BITS-1:0] i_seg_start,
    input logic [COORD_BITS-1:0] i_seg_end,
    input t_count                i_headcount,
    input logic                  i_last_segment,
    input logic                  i_overflow
);

    // A stalled word stays offered.
    `IOSW_ASSERT_NXT(a_out_hold_valid, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // A stalled word keeps its contents.
    `IOSW_ASSERT_NXT(a_out_hold_word, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_seg_start) && $stable(i_seg_end) && $stable(i_headcount) && $stable(i_last_segment) && $stable(i_overflow))

    // The last interval of a batch starts the sweep, so input is held off.
    `IOSW_ASSERT_NXT(a_sweep_blocks_input, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_last, !i_in_ready)

    // While a word that is not the final one is offered, the sweep still runs.
    `IOSW_ASSERT_IMP(a_mid_sweep_no_input, i_clk, i_rst_n, i_out_valid && !i_last_segment, !i_in_ready)

endmodule

bind interval_overlap_sweep iosw_checker #(.COORD_BITS(COORD_BITS)) u_iosw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_last      (i_in.last_interval),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_seg_start    (o_out.seg_start),
    .i_seg_end      (o_out.seg_end),
    .i_headcount    (o_out.headcount),
    .i_last_segment (o_out.last_segment),
    .i_overflow     (o_out.overflow)
);

// ----- sim/tb.sv -----
// ============================================================================
// Interval overlap sweep testbench
// Drives batches of intervals into the sweep block and checks every segment
// word against a predictor that sweeps its own copy of the interval store.
// The sender works in bursts with random gaps and the receiver stalls on a
// pattern of its own, so that idle cycles fall on loading and sweeping alike.
// ============================================================================
module tb;
    import iosw_pkg::*;

    localparam int CW     = COORD_BITS_DEF;
    localparam int MAX_IV = MAX_INTERVALS_DEF;

    // Number of random intervals to send after the directed part.
    localparam int RANDOM_INTERVALS = 360;

    // Shapes of the batches that the random part builds.
    typedef enum {
        B_SPREAD,
        B_CLUSTER,
        B_FULL,
        B_OVERFLOW,
        B_STACK_UP,
        B_STACK_DOWN
    } t_batch_kind;

    // Stall patterns of the receiver.
    typedef enum {
        RX_FREE,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_mode;

    // One segment word as it leaves the block.
    typedef struct {
        logic [CW-1:0] seg_start;
        logic [CW-1:0] seg_end;
        t_count        headcount;
        logic          last_segment;
        logic          overflow;
    } t_segment;

    // Keeps its own interval store, sweeps it on the last interval of a
    // batch and holds the segments still to come, oldest first.
    class overlap_scoreboard;
        logic [CW-1:0] start_store [MAX_IV];
        logic [CW-1:0] end_store [MAX_IV];
        int            held;
        bit            dropped;
        t_segment      expected_q [$];
        int            errors;

        function void note_interval(logic [CW-1:0] s, logic [CW-1:0] e, bit last);
            logic [CW-1:0] coords [$];
            logic [CW-1:0] c;
            t_segment      seg;
            int            pos;
            int            j;
            int            k;
            int            sum;
            int            delta;
            if (held < MAX_IV) begin
                start_store[held] = s;
                end_store[held]   = e;
                held++;
            end else begin
                dropped = 1'b1;
            end
            if (!last)
                return;

            // Sorted list of the distinct coordinates in the store.
            for (j = 0; j < 2 * held; j++) begin
                c   = (j < held) ? start_store[j] : end_store[j - held];
                pos = 0;
                while (pos < coords.size() && coords[pos] < c)
                    pos++;
                if (pos == coords.size() || coords[pos] != c)
                    coords.insert(pos, c);
            end

            // Each segment carries the count that holds after its lower end.
            sum = 0;
            for (k = 0; k < coords.size(); k++) begin
                if (k > 0) begin
                    seg.seg_start    = coords[k-1];
                    seg.seg_end      = coords[k];
                    seg.headcount    = t_count'(sum);
                    seg.last_segment = (k == coords.size() - 1);
                    seg.overflow     = dropped;
                    expected_q.insert(expected_q.size(), seg);
                end
                delta = 0;
                for (j = 0; j < held; j++) begin
                    if (start_store[j] == coords[k])
                        delta++;
                    if (end_store[j] == coords[k])
                        delta--;
                end
                sum += delta;
            end
            held    = 0;
            dropped = 1'b0;
        endfunction

        function void report_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_segment(t_segment got);
            t_segment want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: segment with none expected, actual %0d..%0d count %0d",
                         $time, got.seg_start, got.seg_end, got.headcount);
                return;
            end
            want = expected_q.pop_front();
            report_field("seg_start", want.seg_start, got.seg_start);
            report_field("seg_end", want.seg_end, got.seg_end);
            report_field("headcount", int'(want.headcount), int'(got.headcount));
            report_field("last_segment", want.last_segment, got.last_segment);
            report_field("overflow", want.overflow, got.overflow);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    iosw_in_if  #(.COORD_BITS(CW)) in_ch ();
    iosw_out_if #(.COORD_BITS(CW)) out_ch ();

    interval_overlap_sweep u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    overlap_scoreboard sb = new();

    int intervals_sent;
    int burst_left;

    // Clock.
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial begin
        repeat (600000) @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one interval and wait for its handshake, then idle between
    // bursts.
    task automatic push_interval(logic [CW-1:0] s, logic [CW-1:0] e, bit last);
        int gap;
        in_ch.valid         <= 1'b1;
        in_ch.start_year    <= s;
        in_ch.end_year      <= e;
        in_ch.last_interval <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_interval(s, e, last);
        intervals_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(0, 12);
            gap         = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the sender back until every expected word has come.
    task automatic wait_drained();
        if (in_ch.valid)
            in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // One well-formed batch: random intervals, the final one marked last.
    task automatic run_batch(t_batch_kind kind);
        int            n;
        int            i;
        logic [CW-1:0] base;
        logic [CW-1:0] s;
        logic [CW-1:0] e;
        logic [CW-1:0] lo;
        logic [CW-1:0] hi;
        case (kind)
            B_SPREAD:   n = $urandom_range(1, 6);
            B_CLUSTER:  n = $urandom_range(2, 12);
            B_FULL:     n = MAX_IV;
            B_OVERFLOW: n = $urandom_range(MAX_IV + 1, MAX_IV + 8);
            default:    n = MAX_IV;
        endcase
        base = CW'($urandom);
        lo   = CW'($urandom_range(0, 60000));
        hi   = CW'(lo + $urandom_range(1, 5000));
        for (i = 0; i < n; i++) begin
            case (kind)
                B_SPREAD: begin
                    s = CW'($urandom);
                    e = ($urandom_range(0, 9) == 0) ? s : CW'($urandom);
                end
                B_CLUSTER, B_FULL: begin
                    s = CW'(base + $urandom_range(0, 7));
                    e = CW'(base + $urandom_range(0, 7));
                end
                B_OVERFLOW: begin
                    s = CW'(base + $urandom_range(0, 15));
                    e = CW'(base + $urandom_range(0, 15));
                end
                B_STACK_UP: begin
                    s = lo;
                    e = hi;
                end
                default: begin
                    s = hi;
                    e = lo;
                end
            endcase
            push_interval(s, e, i == n - 1);
        end
    endtask

    // Receiver: checks each accepted word and stalls on its own pattern,
    // with one long hold-off once the block has got going.
    initial begin : sink_side
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        bit       held_once;
        int       seen;
        t_segment got;
        mode         = RX_FREE;
        mode_left    = 0;
        hold_left    = 0;
        held_once    = 1'b0;
        seen         = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) begin
                got.seg_start    = out_ch.seg_start;
                got.seg_end      = out_ch.seg_end;
                got.headcount    = out_ch.headcount;
                got.last_segment = out_ch.last_segment;
                got.overflow     = out_ch.overflow;
                sb.check_segment(got);
                seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (!held_once && seen >= 40) begin
                held_once = 1'b1;
                hold_left = 600;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 150);
            end else begin
                mode_left--;
            end
            if (hold_left > 0)
                out_ch.ready <= 1'b0;
            else if (mode == RX_FREE)
                out_ch.ready <= 1'b1;
            else if (mode == RX_RANDOM)
                out_ch.ready <= 1'($urandom_range(0, 1));
            else
                out_ch.ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // Sender: reset, directed batches, then random batches.
    initial begin : source_side
        int          batch_no;
        int          base_count;
        int          pick;
        t_batch_kind kind;
        in_ch.valid         <= 1'b0;
        in_ch.start_year    <= '0;
        in_ch.end_year      <= '0;
        in_ch.last_interval <= 1'b0;
        rst_n               <= 1'b0;
        intervals_sent = 0;
        burst_left     = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A lone point at either extreme gives a single coordinate and no
        // segment.
        push_interval(16'h0000, 16'h0000, 1'b1);
        push_interval(16'hFFFF, 16'hFFFF, 1'b1);
        // Widest interval, forwards and reversed (count goes negative).
        push_interval(16'h0000, 16'hFFFF, 1'b1);
        push_interval(16'hFFFF, 16'h0000, 1'b1);
        // An end and a start meeting at one coordinate.
        push_interval(16'd10, 16'd20, 1'b0);
        push_interval(16'd15, 16'd30, 1'b0);
        push_interval(16'd20, 16'd25, 1'b1);
        // A zero-count segment between two disjoint intervals.
        push_interval(16'd100, 16'd200, 1'b0);
        push_interval(16'd300, 16'd400, 1'b1);
        // Alternating bit patterns that cancel at each coordinate.
        push_interval(16'hAAAA, 16'h5555, 1'b0);
        push_interval(16'h5555, 16'hAAAA, 1'b1);
        // Duplicate intervals stack up.
        push_interval(16'd7, 16'd9, 1'b0);
        push_interval(16'd7, 16'd9, 1'b1);
        wait_drained();

        // Random part; the first batches force the full store and the count
        // extremes.
        base_count = intervals_sent;
        batch_no   = 0;
        while (intervals_sent - base_count < RANDOM_INTERVALS) begin
            if (batch_no == 0) begin
                kind = B_OVERFLOW;
            end else if (batch_no == 1) begin
                kind = B_STACK_UP;
            end else if (batch_no == 2) begin
                kind = B_STACK_DOWN;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    kind = B_SPREAD;
                else if (pick < 75)
                    kind = B_CLUSTER;
                else if (pick < 85)
                    kind = B_FULL;
                else if (pick < 93)
                    kind = B_OVERFLOW;
                else if (pick < 97)
                    kind = B_STACK_UP;
                else
                    kind = B_STACK_DOWN;
            end
            run_batch(kind);
            if (batch_no == 10)
                wait_drained();
            batch_no++;
        end

        // Let the last words come out, then a short quiet spell.
        wait_drained();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- interval_overlap_sweep.f -----
+incdir+rtl/core
rtl/core/iosw_pkg.sv
rtl/core/iosw_in_if.sv
rtl/core/iosw_out_if.sv
rtl/core/iosw_ram.sv
rtl/core/iosw_ctrl.sv
rtl/core/iosw_dp.sv
rtl/core/interval_overlap_sweep.sv
rtl/core/iosw_checker.sv
sim/tb.sv
